// File: design/cdew_pkg.sv
// Shared constants, codes and control structures of the color delta edge weight block.
package cdew_pkg;

    // Line store depth; kept a power of two so that the store slot is the low column bits.
    localparam int MAX_WIDTH    = 1024;
    localparam int ADDR_W       = $clog2(MAX_WIDTH);
    localparam int WIDTH_LIMIT  = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int HEIGHT_LIMIT = 1024;

    localparam int CH_W     = 8;
    localparam int PIX_W    = 3 * CH_W;
    localparam int POS_W    = 10;
    localparam int CFG_W    = 11;
    localparam int SCALE_W  = 8;
    localparam int WEIGHT_W = 16;
    localparam int STEP_W   = 5;

    localparam int SQRT_STEPS   = 13;
    localparam int TAYLOR_TERMS = 16;

    localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

    // Configuration register indexes.
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_DECAY_SCALE  = 2'd2;

    // Neighbor being weighted.
    localparam logic SIDE_UP   = 1'b0;
    localparam logic SIDE_LEFT = 1'b1;

    // Argument of the exponential series: exactly one, or the fraction of the exponent.
    localparam logic XSEL_ONE  = 1'b0;
    localparam logic XSEL_FRAC = 1'b1;

    // Divider operand source: distance over scale, or series term over its index.
    localparam logic DIV_SEL_A = 1'b0;
    localparam logic DIV_SEL_K = 1'b1;

    typedef struct packed {
        logic              accept;
        logic              side;
        logic              load_sq;
        logic              sqrt_step;
        logic              div_start;
        logic              div_sel;
        logic              take_a;
        logic              exp_init;
        logic              exp_x_sel;
        logic              exp_mul;
        logic              exp_acc;
        logic              exp_end;
        logic              r_init;
        logic              r_mul;
        logic              r_take;
        logic              w_store;
        logic              w_zero;
        logic              out_load;
        logic [STEP_W-1:0] step;
    } cdew_cmd_t;

    typedef struct packed {
        logic       div_done;
        logic       a_big;
        logic [3:0] n_val;
        logic       up_ok;
        logic       left_ok;
        logic       out_free;
    } cdew_stat_t;

endpackage

// File: design/cdew_divider.sv
// Serial restoring divider: 32-bit dividend by 8-bit divisor, one quotient bit per cycle.
module cdew_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [7:0]  divisor,
    output logic [31:0] quotient,
    output logic        done
);
    import cdew_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] quo_reg, quo_next;
    logic [7:0]  rem_reg, rem_next;
    logic [7:0]  dvs_reg, dvs_next;
    logic [8:0]  trial;
    logic [8:0]  diff;

    assign trial = {rem_reg, quo_reg[31]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[7:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial[7:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// File: design/cdew_ctrl.sv
// Sequencer of the edge weight block: steps one pixel through both weights.
module cdew_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  cdew_pkg::cdew_stat_t  stat,
    output cdew_pkg::cdew_cmd_t   cmd
);
    import cdew_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_SIDE    = 4'd1;
    localparam logic [3:0] ST_SQ      = 4'd2;
    localparam logic [3:0] ST_SQRT    = 4'd3;
    localparam logic [3:0] ST_DIVA    = 4'd4;
    localparam logic [3:0] ST_DIVA_W  = 4'd5;
    localparam logic [3:0] ST_CHECK   = 4'd6;
    localparam logic [3:0] ST_EXP_MUL = 4'd7;
    localparam logic [3:0] ST_EXP_DIV = 4'd8;
    localparam logic [3:0] ST_EXP_W   = 4'd9;
    localparam logic [3:0] ST_EXP_END = 4'd10;
    localparam logic [3:0] ST_RMUL    = 4'd11;
    localparam logic [3:0] ST_RTAKE   = 4'd12;
    localparam logic [3:0] ST_WFIN    = 4'd13;
    localparam logic [3:0] ST_OUT     = 4'd14;

    logic [3:0]        state_reg, state_next;
    logic              side_reg, side_next;
    logic              tgt_reg, tgt_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        side_next  = side_reg;
        tgt_next   = tgt_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.side   = side_reg;
        cmd.step   = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    side_next  = SIDE_UP;
                    state_next = ST_SIDE;
                end
            end
            ST_SIDE:
            begin
                if ((side_reg == SIDE_UP && stat.up_ok) ||
                    (side_reg == SIDE_LEFT && stat.left_ok))
                begin
                    state_next = ST_SQ;
                end
                else
                begin
                    // No neighbor on this side: the weight is zero.
                    cmd.w_zero = 1'b1;
                    if (side_reg == SIDE_UP)
                        side_next = SIDE_LEFT;
                    else
                        state_next = ST_OUT;
                end
            end
            ST_SQ:
            begin
                cmd.load_sq = 1'b1;
                step_next   = STEP_W'(SQRT_STEPS - 1);
                state_next  = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (step_reg == '0)
                    state_next = ST_DIVA;
                else
                    step_next = step_reg - 1'b1;
            end
            ST_DIVA:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SEL_A;
                state_next    = ST_DIVA_W;
            end
            ST_DIVA_W:
            begin
                if (stat.div_done)
                begin
                    cmd.take_a = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (stat.a_big)
                begin
                    // Exponent of sixteen or more: the weight underflows to zero.
                    cmd.w_zero = 1'b1;
                    if (side_reg == SIDE_UP)
                    begin
                        side_next  = SIDE_LEFT;
                        state_next = ST_SIDE;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
                else
                begin
                    cmd.r_init   = 1'b1;
                    cmd.exp_init = 1'b1;
                    if (stat.n_val == '0)
                    begin
                        cmd.exp_x_sel = XSEL_FRAC;
                        tgt_next      = XSEL_FRAC;
                    end
                    else
                    begin
                        cmd.exp_x_sel = XSEL_ONE;
                        tgt_next      = XSEL_ONE;
                    end
                    step_next  = STEP_W'(1);
                    state_next = ST_EXP_MUL;
                end
            end
            ST_EXP_MUL:
            begin
                cmd.exp_mul = 1'b1;
                state_next  = ST_EXP_DIV;
            end
            ST_EXP_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_SEL_K;
                state_next    = ST_EXP_W;
            end
            ST_EXP_W:
            begin
                if (stat.div_done)
                begin
                    cmd.exp_acc = 1'b1;
                    if (step_reg == STEP_W'(TAYLOR_TERMS))
                    begin
                        state_next = ST_EXP_END;
                    end
                    else
                    begin
                        step_next  = step_reg + 1'b1;
                        state_next = ST_EXP_MUL;
                    end
                end
            end
            ST_EXP_END:
            begin
                cmd.exp_end = 1'b1;
                if (tgt_reg == XSEL_ONE)
                    step_next = STEP_W'(stat.n_val);
                else
                    step_next = STEP_W'(1);
                state_next = ST_RMUL;
            end
            ST_RMUL:
            begin
                cmd.r_mul  = 1'b1;
                state_next = ST_RTAKE;
            end
            ST_RTAKE:
            begin
                cmd.r_take = 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    if (tgt_reg == XSEL_ONE)
                    begin
                        // Integer part done; now the series of the fraction.
                        cmd.exp_init  = 1'b1;
                        cmd.exp_x_sel = XSEL_FRAC;
                        tgt_next      = XSEL_FRAC;
                        step_next     = STEP_W'(1);
                        state_next    = ST_EXP_MUL;
                    end
                    else
                    begin
                        state_next = ST_WFIN;
                    end
                end
                else
                begin
                    step_next  = step_reg - 1'b1;
                    state_next = ST_RMUL;
                end
            end
            ST_WFIN:
            begin
                cmd.w_store = 1'b1;
                if (side_reg == SIDE_UP)
                begin
                    side_next  = SIDE_LEFT;
                    state_next = ST_SIDE;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            side_reg  <= SIDE_UP;
            tgt_reg   <= XSEL_ONE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            side_reg  <= side_next;
            tgt_reg   <= tgt_next;
            step_reg  <= step_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

// File: design/cdew_datapath.sv
// Datapath: configuration, position counters, line store, weight arithmetic and result register.
module cdew_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cdew_pkg::cdew_cmd_t           cmd,
    output cdew_pkg::cdew_stat_t          stat,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [cdew_pkg::CFG_W-1:0]    cfg_data,
    input  logic [cdew_pkg::CH_W-1:0]     red,
    input  logic [cdew_pkg::CH_W-1:0]     green,
    input  logic [cdew_pkg::CH_W-1:0]     blue,
    input  logic                          frame_start,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic [cdew_pkg::POS_W-1:0]    pixel_row,
    output logic [cdew_pkg::POS_W-1:0]    pixel_col,
    output logic [cdew_pkg::WEIGHT_W-1:0] up_weight,
    output logic                          up_valid,
    output logic [cdew_pkg::WEIGHT_W-1:0] left_weight,
    output logic                          left_valid,
    output logic                          frame_end
);
    import cdew_pkg::*;

    logic [PIX_W-1:0] line_mem [MAX_WIDTH];

    logic [CFG_W-1:0]    width_reg, height_reg;
    logic [SCALE_W-1:0]  scale_reg;
    logic [POS_W-1:0]    col_reg, col_next;
    logic [POS_W-1:0]    row_reg, row_next;
    logic [PIX_W-1:0]    pix_reg, prior_reg, above_reg;
    logic [25:0]         v_reg, root_reg;
    logic [24:0]         a_reg;
    logic [31:0]         x_reg, term_reg, e_reg, r_reg;
    logic signed [33:0]  sum_reg;
    logic [63:0]         prod_reg;
    logic [WEIGHT_W-1:0] up_w_reg, left_w_reg;
    logic                out_valid_reg;
    logic [POS_W-1:0]    out_row_reg, out_col_reg;
    logic [WEIGHT_W-1:0] out_up_reg, out_left_reg;
    logic                out_upv_reg, out_leftv_reg, out_end_reg;

    logic [CFG_W-1:0]   width_eff, height_eff;
    logic [SCALE_W-1:0] scale_eff;
    logic [ADDR_W-1:0]  rd_addr, wr_addr;
    logic [PIX_W-1:0]   nbr;
    logic signed [17:0] dr, dg, db;
    logic [17:0]        sq_r, sq_g, sq_b, s_sum;
    logic [25:0]        bit_val, root_try;
    logic [31:0]        div_dividend, div_quotient;
    logic [7:0]         div_divisor;
    logic               div_done;
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        prod_next;
    logic [32:0]        w_round;
    logic [WEIGHT_W-1:0] w_sat, w_val;
    logic [CFG_W-1:0]   col_inc, row_inc;

    // Range clamps of the configuration.
    always_comb
    begin
        if (width_reg == '0)
            width_eff = CFG_W'(1);
        else if (width_reg > CFG_W'(WIDTH_LIMIT))
            width_eff = CFG_W'(WIDTH_LIMIT);
        else
            width_eff = width_reg;
        if (height_reg == '0)
            height_eff = CFG_W'(1);
        else if (height_reg > CFG_W'(HEIGHT_LIMIT))
            height_eff = CFG_W'(HEIGHT_LIMIT);
        else
            height_eff = height_reg;
        scale_eff = (scale_reg == '0) ? SCALE_W'(1) : scale_reg;
    end

    // Squared color distance toward the selected neighbor.
    assign nbr  = (cmd.side == SIDE_LEFT) ? prior_reg : above_reg;
    assign dr   = 18'($signed({1'b0, pix_reg[7:0]}))   - 18'($signed({1'b0, nbr[7:0]}));
    assign dg   = 18'($signed({1'b0, pix_reg[15:8]}))  - 18'($signed({1'b0, nbr[15:8]}));
    assign db   = 18'($signed({1'b0, pix_reg[23:16]})) - 18'($signed({1'b0, nbr[23:16]}));
    assign sq_r = dr * dr;
    assign sq_g = dg * dg;
    assign sq_b = db * db;
    assign s_sum = sq_r + sq_g + sq_b;

    // One digit of the square root per step, highest digit first.
    assign bit_val  = 26'(1) << {cmd.step[3:0], 1'b0};
    assign root_try = root_reg + bit_val;

    assign div_dividend = (cmd.div_sel == DIV_SEL_A) ?
                          {7'b0, root_reg[12:0], 12'b0} : prod_reg[62:31];
    assign div_divisor  = (cmd.div_sel == DIV_SEL_A) ? scale_eff : 8'(cmd.step);

    cdew_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .done     (div_done)
    );

    // Shared multiplier: series term times argument, or running product times exponential.
    assign mul_a     = cmd.exp_mul ? term_reg : r_reg;
    assign mul_b     = cmd.exp_mul ? x_reg : e_reg;
    assign prod_next = mul_a * mul_b;

    // Round Q.31 to Q0.16 and saturate one to full scale.
    assign w_round = {1'b0, r_reg} + 33'h0000_4000;
    assign w_sat   = (|w_round[32:31]) ? {WEIGHT_W{1'b1}} : w_round[30:15];
    assign w_val   = cmd.w_zero ? '0 : w_sat;

    assign col_inc = {1'b0, col_reg} + CFG_W'(1);
    assign row_inc = {1'b0, row_reg} + CFG_W'(1);
    assign rd_addr = frame_start ? '0 : ADDR_W'(col_reg);
    assign wr_addr = ADDR_W'(col_reg);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.accept && frame_start)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (cmd.out_load)
        begin
            if (col_inc >= width_eff)
            begin
                col_next = '0;
                row_next = (row_inc >= height_eff) ? '0 : row_inc[POS_W-1:0];
            end
            else
            begin
                col_next = col_inc[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= CFG_W'(640);
            height_reg    <= CFG_W'(480);
            scale_reg     <= SCALE_W'(30);
            col_reg       <= '0;
            row_reg       <= '0;
            prior_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                    CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    CFG_DECAY_SCALE:  scale_reg  <= cfg_data[SCALE_W-1:0];
                    default:          ;
                endcase
            end
            col_reg <= col_next;
            row_reg <= row_next;
            if (cmd.out_load)
                prior_reg <= pix_reg;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Line store: read when the pixel is taken, written when its result leaves.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            above_reg <= line_mem[rd_addr];
        if (cmd.out_load)
            line_mem[wr_addr] <= pix_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            pix_reg <= {blue, green, red};
        if (cmd.load_sq)
        begin
            v_reg    <= {s_sum, 8'b0};
            root_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            if (v_reg >= root_try)
            begin
                v_reg    <= v_reg - root_try;
                root_reg <= (root_reg >> 1) + bit_val;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
        end
        if (cmd.take_a)
            a_reg <= div_quotient[24:0];
        if (cmd.exp_init)
        begin
            term_reg <= ONE_Q31;
            sum_reg  <= $signed({2'b00, ONE_Q31});
            x_reg    <= (cmd.exp_x_sel == XSEL_FRAC) ? {1'b0, a_reg[15:0], 15'b0} : ONE_Q31;
        end
        else if (cmd.exp_acc)
        begin
            term_reg <= div_quotient;
            if (cmd.step[0])
                sum_reg <= sum_reg - $signed({2'b00, div_quotient});
            else
                sum_reg <= sum_reg + $signed({2'b00, div_quotient});
        end
        if (cmd.exp_end)
            e_reg <= sum_reg[33] ? '0 : sum_reg[31:0];
        if (cmd.exp_mul || cmd.r_mul)
            prod_reg <= prod_next;
        if (cmd.r_init)
            r_reg <= ONE_Q31;
        else if (cmd.r_take)
            r_reg <= prod_reg[62:31];
        if ((cmd.w_store || cmd.w_zero) && cmd.side == SIDE_UP)
            up_w_reg <= w_val;
        if ((cmd.w_store || cmd.w_zero) && cmd.side == SIDE_LEFT)
            left_w_reg <= w_val;
        if (cmd.out_load)
        begin
            out_row_reg   <= row_reg;
            out_col_reg   <= col_reg;
            out_up_reg    <= up_w_reg;
            out_left_reg  <= left_w_reg;
            out_upv_reg   <= (row_reg != '0);
            out_leftv_reg <= (col_reg != '0);
            out_end_reg   <= ({1'b0, row_reg} == height_eff - CFG_W'(1)) &&
                             ({1'b0, col_reg} == width_eff - CFG_W'(1));
        end
    end

    assign stat.div_done = div_done;
    assign stat.a_big    = |a_reg[24:20];
    assign stat.n_val    = a_reg[19:16];
    assign stat.up_ok    = (row_reg != '0);
    assign stat.left_ok  = (col_reg != '0);
    assign stat.out_free = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign pixel_row   = out_row_reg;
    assign pixel_col   = out_col_reg;
    assign up_weight   = out_up_reg;
    assign up_valid    = out_upv_reg;
    assign left_weight = out_left_reg;
    assign left_valid  = out_leftv_reg;
    assign frame_end   = out_end_reg;

endmodule

// File: design/color_delta_edge_weight.sv
// Top level of the color delta edge weight block: sequencer, datapath and checks.
//
// Pixels enter in raster order on the input channel (in_valid, in_stall, red, green,
// blue, frame_start); a transfer happens when in_valid is high and in_stall is low.
// frame_start puts the pixel at row 0, column 0; otherwise the position advances by
// itself and wraps at the configured width and height.
// Each pixel yields one result on the output channel: its position, the Q0.16 weights
// exp(-d/decay_scale) toward the pixel above and the pixel at left, their valid flags
// and frame_end on the last pixel of the frame.
// The block works on one pixel at a time. A weight takes a 13-step square root, one
// serial division and one 16-term exponential series of the fraction of the exponent,
// preceded, for an exponent of one or more, by a series at one and n multiplies by
// exp(-1) for integer part n; each term costs one multiply and one division, and the
// serial divider sets the pace. A missing neighbor skips all of this and a saturated
// exponent skips the series.
// A finished result waits in an output register while the next pixel is taken in; a
// stalled receiver only holds up the pixel after that one. Reset clears the position to
// row 0, column 0, empties the output register and loads width 640, height 480 and scale
// 30. The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is always
// ready; the user must write it only while the block is idle, which is not enforced.
module color_delta_edge_weight (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [cdew_pkg::CH_W-1:0]     red,
    input  logic [cdew_pkg::CH_W-1:0]     green,
    input  logic [cdew_pkg::CH_W-1:0]     blue,
    input  logic                          frame_start,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [cdew_pkg::POS_W-1:0]    pixel_row,
    output logic [cdew_pkg::POS_W-1:0]    pixel_col,
    output logic [cdew_pkg::WEIGHT_W-1:0] up_weight,
    output logic                          up_valid,
    output logic [cdew_pkg::WEIGHT_W-1:0] left_weight,
    output logic                          left_valid,
    output logic                          frame_end,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [cdew_pkg::CFG_W-1:0]    cfg_data
);
    import cdew_pkg::*;

    cdew_cmd_t  cmd;
    cdew_stat_t stat;

    // Registers are plain flops, so a write transfer is taken in every cycle.
    assign cfg_ready = 1'b1;

    cdew_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    cdew_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .frame_start (frame_start),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .pixel_row   (pixel_row),
        .pixel_col   (pixel_col),
        .up_weight   (up_weight),
        .up_valid    (up_valid),
        .left_weight (left_weight),
        .left_valid  (left_valid),
        .frame_end   (frame_end)
    );

`ifndef SYNTHESIS
    // A pixel transfer always starts work, so the next pixel is held off.
    a_accept_holds_off: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken again right after a pixel transfer");

    // A new result never overwrites one the receiver has not taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || !out_stall))
        else $error("result register loaded while a stalled result is held");

    // Missing neighbors carry zero weight.
    a_up_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !up_valid) |-> (up_weight == '0))
        else $error("up weight nonzero without an upper neighbor");

    a_left_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !left_valid) |-> (left_weight == '0))
        else $error("left weight nonzero without a left neighbor");
`endif

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the color delta edge weight block.
module tb;
    import cdew_pkg::*;

    // Clock and reset shape.
    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 9;

    // Flow control: share of cycles in which either side rests, and the calm window
    // (counted in transfers) during which neither side rests at all.
    localparam int IDLE_PERCENT = 19;
    localparam int CALM_FIRST   = 900;
    localparam int CALM_LAST    = 1150;

    // The receiver holds off once, long enough for the block to finish one pixel into
    // its output register, finish the next one and then push back on its input.
    localparam int HOLDOFF_AT     = 520;
    localparam int HOLDOFF_CYCLES = 6000;

    // A weight with a large exponent is the slowest case, and a pixel with both neighbors
    // needs two such weights; the settle time covers one such pixel.
    localparam int SETTLE_CYCLES = 3000;

    localparam int RANDOM_PHASES = 11;
    localparam int PHASE_PIXELS  = 145;
    localparam int REPORT_LIMIT  = 10;

    // Q.31 one and the exponent (Q.16) at which the weight is taken as zero.
    localparam longint unsigned Q31_ONE = 64'h8000_0000;
    localparam int unsigned EXPONENT_LIMIT = 32'd16 << 16;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            frame_start;
    } pixel_item_t;

    typedef struct packed {
        logic [POS_W-1:0]    row;
        logic [POS_W-1:0]    col;
        logic [WEIGHT_W-1:0] up_w;
        logic                up_v;
        logic [WEIGHT_W-1:0] left_w;
        logic                left_v;
        logic                last;
    } edge_result_t;

    // Every input of the block holds a known value from time zero.
    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_stall;
    logic [CH_W-1:0]     red         = '0;
    logic [CH_W-1:0]     green       = '0;
    logic [CH_W-1:0]     blue        = '0;
    logic                frame_start = 1'b0;
    logic                out_valid;
    logic                out_stall   = 1'b0;
    logic [POS_W-1:0]    pixel_row;
    logic [POS_W-1:0]    pixel_col;
    logic [WEIGHT_W-1:0] up_weight;
    logic                up_valid;
    logic [WEIGHT_W-1:0] left_weight;
    logic                left_valid;
    logic                frame_end;
    logic                cfg_valid   = 1'b0;
    logic                cfg_ready;
    logic [1:0]          cfg_index   = '0;
    logic [CFG_W-1:0]    cfg_data    = '0;

    // Register values as last written; the predictor and the stimulus generator both
    // work from them, and they only change while the block is idle.
    logic [CFG_W-1:0]   cfg_width  = 11'd640;
    logic [CFG_W-1:0]   cfg_height = 11'd480;
    logic [SCALE_W-1:0] cfg_scale  = 8'd30;

    // Predictor state: the previous row, the previous pixel and the raster position.
    logic [PIX_W-1:0] line_store [MAX_WIDTH];
    logic [PIX_W-1:0] prior_color = '0;
    logic [POS_W-1:0] pred_col    = '0;
    logic [POS_W-1:0] pred_row    = '0;

    // Generator view of the raster position and of how many store columns hold data.
    logic [POS_W-1:0] gen_col     = '0;
    logic [POS_W-1:0] gen_row     = '0;
    int               filled_cols = 0;
    logic [PIX_W-1:0] last_queued = '0;

    pixel_item_t  pixel_queue[$];
    edge_result_t expected_weights[$];
    pixel_item_t  issue_item;
    edge_result_t observed;
    edge_result_t wanted;

    int pixels_accepted = 0;
    int results_seen    = 0;
    int fault_count     = 0;
    int holdoff_left    = 0;
    logic holdoff_done  = 1'b0;

    color_delta_edge_weight DUT (.*);

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------------------
    // Weight arithmetic
    // ------------------------------------------------------------------------------

    // exp(-x) for x in Q.31 as the alternating 16-term series, every term truncated.
    function automatic longint unsigned neg_exp_q31(input longint unsigned x);
        longint            acc;
        longint unsigned   term;
        longint unsigned   k;
        acc  = longint'(Q31_ONE);
        term = Q31_ONE;
        for (k = 1; k <= TAYLOR_TERMS; k++)
        begin
            term = ((term * x) >> 31) / k;
            if (k[0])
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        return (acc < 0) ? 64'd0 : acc;
    endfunction

    // Largest root whose square does not exceed v, found one bit at a time.
    function automatic int unsigned floor_root(input int unsigned v);
        int unsigned root;
        int unsigned trial;
        int          b;
        root = 0;
        for (b = 15; b >= 0; b--)
        begin
            trial = root | (32'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    function automatic logic [WEIGHT_W-1:0] contrast_weight(input logic [PIX_W-1:0] a_pix,
                                                            input logic [PIX_W-1:0] b_pix,
                                                            input logic [SCALE_W-1:0] scale);
        int              dr;
        int              dg;
        int              db;
        int unsigned     color_dist;
        int unsigned     divisor;
        int unsigned     expo;
        int unsigned     n_int;
        longint unsigned r;
        longint unsigned e_one;
        longint unsigned w;
        dr = int'(a_pix[7:0]) - int'(b_pix[7:0]);
        dg = int'(a_pix[15:8]) - int'(b_pix[15:8]);
        db = int'(a_pix[23:16]) - int'(b_pix[23:16]);
        // Distance with four fraction bits, then the exponent in Q.16.
        color_dist = floor_root((dr * dr + dg * dg + db * db) << 8);
        divisor    = (scale == 0) ? 1 : scale;
        expo       = color_dist * 4096 / divisor;
        if (expo >= EXPONENT_LIMIT)
            return '0;
        // exp(-a) = exp(-1)^n * exp(-fraction).
        n_int = expo >> 16;
        r     = Q31_ONE;
        e_one = neg_exp_q31(Q31_ONE);
        repeat (n_int)
            r = (r * e_one) >> 31;
        r = (r * neg_exp_q31(longint'(expo & 32'hFFFF) << 15)) >> 31;
        w = (r + (64'd1 << 14)) >> 15;
        return (w > 65535) ? 16'hFFFF : w[15:0];
    endfunction

    // ------------------------------------------------------------------------------
    // Raster position
    // ------------------------------------------------------------------------------

    function automatic int width_in_use(input logic [CFG_W-1:0] w);
        if (w == 0)
            return 1;
        return (w > WIDTH_LIMIT) ? WIDTH_LIMIT : int'(w);
    endfunction

    function automatic int height_in_use(input logic [CFG_W-1:0] h);
        if (h == 0)
            return 1;
        return (h > HEIGHT_LIMIT) ? HEIGHT_LIMIT : int'(h);
    endfunction

    // A column at or past the width (possible after the width shrinks) wraps to the
    // next row just as the last column does; the row wraps after the last row.
    function automatic void advance_position(input int w, input int h,
                                             inout logic [POS_W-1:0] col,
                                             inout logic [POS_W-1:0] row);
        if (col + 1 >= w)
        begin
            col = '0;
            if (row + 1 >= h)
                row = '0;
            else
                row = row + 1'b1;
        end
        else
        begin
            col = col + 1'b1;
        end
    endfunction

    // Works out the result of one accepted pixel and moves the predictor state on.
    function automatic void predict_pixel(input pixel_item_t px);
        logic [PIX_W-1:0] color;
        edge_result_t     res;
        int               w;
        int               h;
        color = {px.blue, px.green, px.red};
        w = width_in_use(cfg_width);
        h = height_in_use(cfg_height);
        if (px.frame_start)
        begin
            pred_col = '0;
            pred_row = '0;
        end
        res.row    = pred_row;
        res.col    = pred_col;
        res.up_v   = (pred_row != 0);
        res.left_v = (pred_col != 0);
        res.up_w   = res.up_v ? contrast_weight(color, line_store[pred_col], cfg_scale) : '0;
        res.left_w = res.left_v ? contrast_weight(color, prior_color, cfg_scale) : '0;
        res.last   = (pred_row == h - 1) && (pred_col == w - 1);
        expected_weights.push_back(res);
        line_store[pred_col] = color;
        prior_color = color;
        advance_position(w, h, pred_col, pred_row);
    endfunction

    // ------------------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------------------

    // The line store holds nothing defined in a column until some row has passed it.
    // Columns fill from zero upward, so the filled part is always a prefix; a pixel
    // below the first row that would land past it opens a new frame instead.
    function automatic void queue_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                                        input logic [CH_W-1:0] b, input logic fs);
        pixel_item_t item;
        if (!fs && gen_row != 0 && gen_col >= filled_cols)
            fs = 1'b1;
        if (fs)
        begin
            gen_col = '0;
            gen_row = '0;
        end
        if (gen_col >= filled_cols)
            filled_cols = gen_col + 1;
        item.red         = r;
        item.green       = g;
        item.blue        = b;
        item.frame_start = fs;
        pixel_queue.push_back(item);
        last_queued = {b, g, r};
        advance_position(width_in_use(cfg_width), height_in_use(cfg_height), gen_col, gen_row);
    endfunction

    // Partly random colors, with a good share close to or equal to the previous pixel so
    // that small exponents and the saturated weight turn up often, and channels at 0 or 255.
    function automatic void queue_random_pixel();
        logic [CH_W-1:0] ch [3];
        int              k;
        int              v;
        int unsigned     pick;
        pick = $urandom_range(9);
        for (k = 0; k < 3; k++)
        begin
            v = int'(last_queued[8*k +: 8]);
            if (pick <= 3)
                v = $urandom_range(255);
            else if (pick <= 6)
                v = v + int'($urandom_range(24)) - 12;
            else if (pick >= 8)
                v = $urandom_range(1) ? 255 : 0;
            if (v < 0)
                v = 0;
            if (v > 255)
                v = 255;
            ch[k] = v[7:0];
        end
        queue_pixel(ch[0], ch[1], ch[2], $urandom_range(99) < 2);
    endfunction

    function automatic string describe(input edge_result_t r);
        return $sformatf("row %0d col %0d up %0d/%0d left %0d/%0d end %0d",
                         r.row, r.col, r.up_w, r.up_v, r.left_w, r.left_v, r.last);
    endfunction

    // One register transfer on the configuration channel.
    task automatic write_register(input logic [1:0] reg_index, input logic [CFG_W-1:0] reg_value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= reg_index;
        cfg_data  <= reg_value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (reg_index)
            CFG_IMAGE_WIDTH:  cfg_width  = reg_value;
            CFG_IMAGE_HEIGHT: cfg_height = reg_value;
            CFG_DECAY_SCALE:  cfg_scale  = reg_value[SCALE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                             input logic [CFG_W-1:0] s);
        write_register(CFG_IMAGE_WIDTH, w);
        write_register(CFG_IMAGE_HEIGHT, h);
        write_register(CFG_DECAY_SCALE, s);
    endtask

    // The block is idle once every queued pixel has gone over and every result is back.
    task automatic wait_until_drained();
        while (pixel_queue.size() != 0 || in_valid || expected_weights.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------------
    // Pixel driver
    // ------------------------------------------------------------------------------

    // A pixel is predicted at the edge where its transfer happens. A new one is only
    // put up once the channel is free, and a stalled pixel stays on the wires as it is.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            red         <= '0;
            green       <= '0;
            blue        <= '0;
            frame_start <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_pixel({red, green, blue, frame_start});
                pixels_accepted <= pixels_accepted + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (pixel_queue.size() != 0 &&
                    ((pixels_accepted >= CALM_FIRST && pixels_accepted < CALM_LAST) ||
                     $urandom_range(99) >= IDLE_PERCENT))
                begin
                    issue_item  = pixel_queue.pop_front();
                    red         <= issue_item.red;
                    green       <= issue_item.green;
                    blue        <= issue_item.blue;
                    frame_start <= issue_item.frame_start;
                    in_valid    <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------------
    // Receiver back-pressure
    // ------------------------------------------------------------------------------

    // Random stalls, none inside the calm window, and one long hold-off started from a
    // point in the run where the sender still has plenty to offer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall    <= 1'b0;
            holdoff_left <= 0;
            holdoff_done <= 1'b0;
        end
        else if (holdoff_left != 0)
        begin
            holdoff_left <= holdoff_left - 1;
            out_stall    <= (holdoff_left != 1);
        end
        else if (!holdoff_done && pixels_accepted >= HOLDOFF_AT)
        begin
            holdoff_done <= 1'b1;
            holdoff_left <= HOLDOFF_CYCLES;
            out_stall    <= 1'b1;
        end
        else if (results_seen >= CALM_FIRST && results_seen < CALM_LAST)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    // ------------------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------------------

    // Each result transfer is matched against the oldest prediction; a result with
    // nothing pending is a failure as well.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            observed.row    = pixel_row;
            observed.col    = pixel_col;
            observed.up_w   = up_weight;
            observed.up_v   = up_valid;
            observed.left_w = left_weight;
            observed.left_v = left_valid;
            observed.last   = frame_end;
            results_seen <= results_seen + 1;
            if (expected_weights.size() == 0)
            begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("%0t: result with no pixel pending: %s", $realtime,
                             describe(observed));
            end
            else
            begin
                wanted = expected_weights.pop_front();
                if (observed !== wanted)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display("%0t: mismatch, expected %s, actual %s", $realtime,
                                 describe(wanted), describe(observed));
                end
            end
        end
    end

    // ------------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------------

    initial
    begin
        int          phase;
        logic [10:0] w_val;
        logic [10:0] h_val;
        logic [10:0] s_val;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // A 4x3 frame: black and white neighbors (largest distance, the longest
        // exponent chain), identical neighbors (weight saturates), single-channel
        // steps, near colors, the frame end, and a next frame without frame_start.
        write_all(11'd4, 11'd3, 11'd30);
        queue_pixel(8'd0,   8'd0,   8'd0,   1'b1);
        queue_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        queue_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        queue_pixel(8'd255, 8'd0,   8'd0,   1'b0);
        queue_pixel(8'd0,   8'd0,   8'd0,   1'b0);
        queue_pixel(8'd0,   8'd255, 8'd0,   1'b0);
        queue_pixel(8'd255, 8'd255, 8'd254, 1'b0);
        queue_pixel(8'd0,   8'd0,   8'd255, 1'b0);
        queue_pixel(8'd128, 8'd64,  8'd32,  1'b0);
        queue_pixel(8'd127, 8'd65,  8'd33,  1'b0);
        queue_pixel(8'd1,   8'd2,   8'd3,   1'b0);
        queue_pixel(8'd254, 8'd253, 8'd252, 1'b0);
        queue_pixel(8'd10,  8'd20,  8'd30,  1'b0);
        wait_until_drained();

        // Zero width acts as one, an oversize height as the limit, zero scale as one;
        // a unit distance then gives an exponent of exactly one.
        write_all(11'd0, 11'd2047, 11'd0);
        queue_pixel(8'd10,  8'd10,  8'd10,  1'b1);
        queue_pixel(8'd11,  8'd10,  8'd10,  1'b0);
        queue_pixel(8'd11,  8'd10,  8'd10,  1'b0);
        queue_pixel(8'd0,   8'd0,   8'd0,   1'b0);
        queue_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        wait_until_drained();

        // Oversize width, zero height, largest scale: a single row that keeps going.
        write_all(11'd2047, 11'd0, 11'd255);
        queue_pixel(8'd0,   8'd0,   8'd0,   1'b1);
        queue_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        queue_pixel(8'd200, 8'd100, 8'd50,  1'b0);
        queue_pixel(8'd201, 8'd99,  8'd52,  1'b0);
        queue_pixel(8'd0,   8'd255, 8'd0,   1'b0);
        queue_pixel(8'd255, 8'd0,   8'd255, 1'b0);
        wait_until_drained();

        // Shrink the width below the current column: that pixel is still handled at
        // its column, then the position wraps to the next row.
        write_register(CFG_IMAGE_WIDTH, 11'd3);
        write_register(CFG_IMAGE_HEIGHT, 11'd4);
        queue_pixel(8'd40, 8'd40, 8'd40, 1'b0);
        queue_pixel(8'd41, 8'd40, 8'd40, 1'b0);
        wait_until_drained();

        // Random phases, each under its own setting, the extremes among them.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            w_val = 11'($urandom_range(24, 2));
            h_val = 11'($urandom_range(12, 2));
            s_val = 11'($urandom_range(255, 1));
            case (phase)
                0:
                begin
                    w_val = 11'd1024;
                    h_val = 11'd1024;
                    s_val = 11'd1;
                end
                1:
                begin
                    w_val = 11'd1;
                    h_val = 11'($urandom_range(30, 2));
                    s_val = 11'd255;
                end
                2:
                begin
                    w_val = 11'($urandom_range(40, 2));
                    h_val = 11'd1;
                end
                3:
                begin
                    w_val = 11'd640;
                    h_val = 11'd480;
                    s_val = 11'd30;
                end
                4:
                begin
                    w_val = 11'd2;
                    h_val = 11'd2;
                end
                default: ;
            endcase
            write_all(w_val, h_val, s_val);
            repeat (PHASE_PIXELS) queue_random_pixel();
            wait_until_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fault_count == 0 && expected_weights.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial
    begin
        #250_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
design/cdew_pkg.sv
design/cdew_divider.sv
design/cdew_ctrl.sv
design/cdew_datapath.sv
design/color_delta_edge_weight.sv
bench/tb.sv
